// ===== design/shfe_pkg.sv =====
// ----------------------------------------------------------------------------
// shfe_pkg
// Shared types and constants of the sync header frame extractor.
// ----------------------------------------------------------------------------
`default_nettype none

package shfe_pkg;

    localparam int MAX_HEADER_BYTES_DEF = 8;
    localparam int MAX_FRAME_BYTES_DEF  = 4096;
    localparam int QUEUE_DEPTH          = 4;

    localparam int HLEN_W = 4;
    localparam int PAT_W  = 64;
    localparam int FLEN_W = 13;
    localparam int CIDX_W = 2;

    typedef enum logic [CIDX_W-1:0] {
        CFG_HEADER_LENGTH  = 2'd0,
        CFG_HEADER_PATTERN = 2'd1,
        CFG_FRAME_LENGTH   = 2'd2
    } t_cfg_index;

    // One unit of work for the output side: a plain frame byte, or a
    // header burst of hdr_len bytes taken from the pattern register.
    typedef struct packed {
        logic [7:0]        data;
        logic              is_hdr;
        logic              first;
        logic              eof;
        logic [HLEN_W-1:0] hdr_len;
    } t_job;

endpackage

`default_nettype wire

// ===== design/shfe_front.sv =====
// ----------------------------------------------------------------------------
// shfe_front
// Hunts for the sync header and tracks frame position; queues one job per
// byte that yields output.
// ----------------------------------------------------------------------------
`default_nettype none

module shfe_front
    import shfe_pkg::*;
#(
    parameter int MAX_HEADER_BYTES = MAX_HEADER_BYTES_DEF,
    parameter int MAX_FRAME_BYTES  = MAX_FRAME_BYTES_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [7:0]        i_byte,
    input  wire logic [HLEN_W-1:0] i_header_length,
    input  wire logic [PAT_W-1:0]  i_header_pattern,
    input  wire logic [FLEN_W-1:0] i_frame_length,
    input  wire logic              i_q_full,
    output logic                   o_push,
    output t_job                   o_job
);

    localparam int FILL_W = $clog2(MAX_HEADER_BYTES + 1);
    localparam int WIN_W  = 8 * MAX_HEADER_BYTES;
    localparam int CNT_W  = $clog2(MAX_FRAME_BYTES + 1);
    localparam int LEN_W  = (CNT_W > FLEN_W) ? CNT_W : FLEN_W;

    localparam logic [HLEN_W-1:0] MAXH_L    = HLEN_W'(MAX_HEADER_BYTES);
    localparam logic [LEN_W-1:0]  MAXF_L    = LEN_W'(MAX_FRAME_BYTES);
    localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(MAX_HEADER_BYTES);

    logic [WIN_W-1:0]  r_window, n_window;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic              r_in_frame, n_in_frame;
    logic [CNT_W-1:0]  r_cnt, n_cnt;

    logic [HLEN_W-1:0]                hl;
    logic [LEN_W-1:0]                 hl_w, fl_a, fl_b, fl_c, fl;
    logic [WIN_W+7:0]                 cat;
    logic [MAX_HEADER_BYTES-1:0][7:0] win;
    logic [7:0][7:0]                  pat;
    logic [HLEN_W-1:0]                pidx;
    logic [FILL_W-1:0]                fill_next;
    logic                             fill_ok, match, single, accept, done, hdr_end;
    logic [CNT_W-1:0]                 cnt_inc;

    always_comb begin
        hl   = (i_header_length > MAXH_L) ? MAXH_L : i_header_length;
        hl_w = LEN_W'(hl);
        fl_a = LEN_W'(i_frame_length);
        fl_b = (fl_a < hl_w) ? hl_w : fl_a;
        fl_c = (fl_b == '0) ? LEN_W'(1) : fl_b;
        fl   = (fl_c > MAXF_L) ? MAXF_L : fl_c;

        cat       = {r_window, i_byte};
        win       = cat[WIN_W-1:0];
        pat       = i_header_pattern;
        fill_next = (r_fill == FULL_FILL) ? r_fill : r_fill + 1'b1;
        fill_ok   = HLEN_W'(fill_next) >= hl;

        // byte i back from the newest must equal header byte hl-1-i
        match = 1'b1;
        pidx  = '0;
        for (int i = 0; i < MAX_HEADER_BYTES; i++) begin
            pidx = hl - HLEN_W'(i + 1);
            if ((HLEN_W'(i) < hl) && (win[i] != pat[pidx[2:0]])) begin
                match = 1'b0;
            end
        end

        single  = r_in_frame || (hl == '0);
        accept  = i_valid && o_ready;
        cnt_inc = r_cnt + 1'b1;
        done    = LEN_W'(cnt_inc) >= fl;
        hdr_end = hl_w >= fl;
    end

    assign o_ready = !i_q_full;
    assign o_push  = accept && (single || (fill_ok && match));

    always_comb begin
        o_job = '0;
        if (single) begin
            o_job.data  = i_byte;
            o_job.first = !r_in_frame;
            o_job.eof   = done;
        end else begin
            o_job.is_hdr  = 1'b1;
            o_job.first   = 1'b1;
            o_job.eof     = hdr_end;
            o_job.hdr_len = hl;
        end
    end

    always_comb begin
        n_window   = r_window;
        n_fill     = r_fill;
        n_in_frame = r_in_frame;
        n_cnt      = r_cnt;
        if (accept) begin
            if (single) begin
                if (done) begin
                    n_in_frame = 1'b0;
                    n_cnt      = '0;
                    n_window   = '0;
                    n_fill     = '0;
                end else begin
                    n_in_frame = 1'b1;
                    n_cnt      = cnt_inc;
                end
            end else if (fill_ok && match) begin
                n_window = '0;
                n_fill   = '0;
                if (hdr_end) begin
                    n_in_frame = 1'b0;
                    n_cnt      = '0;
                end else begin
                    n_in_frame = 1'b1;
                    n_cnt      = CNT_W'(hl);
                end
            end else begin
                n_window = cat[WIN_W-1:0];
                n_fill   = fill_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window   <= '0;
            r_fill     <= '0;
            r_in_frame <= 1'b0;
            r_cnt      <= '0;
        end else begin
            r_window   <= n_window;
            r_fill     <= n_fill;
            r_in_frame <= n_in_frame;
            r_cnt      <= n_cnt;
        end
    end

endmodule

`default_nettype wire

// ===== design/shfe_queue.sv =====
// ----------------------------------------------------------------------------
// shfe_queue
// Short job queue between the hunting front and the output back end.
// ----------------------------------------------------------------------------
`default_nettype none

module shfe_queue
    import shfe_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_job      i_job,
    input  wire logic i_pop,
    output t_job      o_head,
    output logic      o_full,
    output logic      o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp, n_wp, r_rp, n_rp;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rp];

    always_comb begin
        n_wp    = r_wp;
        n_rp    = r_rp;
        n_count = r_count;
        if (i_push) begin
            n_wp = (r_wp == LAST_PTR) ? '0 : r_wp + 1'b1;
        end
        if (i_pop) begin
            n_rp = (r_rp == LAST_PTR) ? '0 : r_rp + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("job pushed into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("job popped from empty queue");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("queue count out of range");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count missed a push");

endmodule

`default_nettype wire

// ===== design/shfe_back.sv =====
// ----------------------------------------------------------------------------
// shfe_back
// Expands queued jobs into output items: one per frame byte, hdr_len per
// header burst, held in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module shfe_back
    import shfe_pkg::*;
#(
    parameter int MAX_HEADER_BYTES = MAX_HEADER_BYTES_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  t_job                  i_head,
    input  wire logic             i_empty,
    output logic                  o_pop,
    input  wire logic [PAT_W-1:0] i_header_pattern,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic [7:0]            o_frame_byte,
    output logic                  o_first_of_frame,
    output logic                  o_end_of_frame,
    output logic                  o_last_of_run
);

    localparam int IW = (MAX_HEADER_BYTES > 1) ? $clog2(MAX_HEADER_BYTES) : 1;

    logic          r_valid, n_valid;
    logic [IW-1:0] r_idx, n_idx;
    logic [7:0]    r_byte;
    logic          r_first, r_eof, r_last;

    logic [7:0][7:0] pat;
    logic            hdr_last, entry_last, load, take;
    logic [7:0]      res_byte;
    logic            res_first, res_eof;

    always_comb begin
        pat        = i_header_pattern;
        hdr_last   = HLEN_W'(r_idx) == (i_head.hdr_len - 1'b1);
        entry_last = !i_head.is_hdr || hdr_last;
        load       = !r_valid || i_ready;
        take       = load && !i_empty;

        if (i_head.is_hdr) begin
            res_byte  = pat[3'(r_idx)];
            res_first = (r_idx == '0);
            res_eof   = hdr_last && i_head.eof;
        end else begin
            res_byte  = i_head.data;
            res_first = i_head.first;
            res_eof   = i_head.eof;
        end

        n_valid = load ? !i_empty : r_valid;
        n_idx   = r_idx;
        if (take) begin
            n_idx = entry_last ? '0 : r_idx + 1'b1;
        end
    end

    assign o_pop            = take && entry_last;
    assign o_valid          = r_valid;
    assign o_frame_byte     = r_byte;
    assign o_first_of_frame = r_first;
    assign o_end_of_frame   = r_eof;
    assign o_last_of_run    = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_byte  <= res_byte;
            r_first <= res_first;
            r_eof   <= res_eof;
            r_last  <= entry_last;
        end
    end

    // mid-burst: the header job must still sit at the queue head
    a_burst_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_idx != '0) |-> (!i_empty && i_head.is_hdr))
        else $error("header burst lost its queue entry");

    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_last) |-> (!i_empty && i_head.is_hdr))
        else $error("item not last of run without pending burst");

endmodule

`default_nettype wire

// ===== design/sync_header_frame_extractor_top.sv =====
// ----------------------------------------------------------------------------
// sync_header_frame_extractor_top
// Pipeline: an accepted item's job passes one queue stage, then one output register.
// Throughput: one input byte per cycle while the queue is not full; a header match
//   emits header_length results, one per cycle from the output expander while the
//   output is ready; a 4-entry queue absorbs them.
// Reset: synchronous; hunting with an empty window, queue and output empty,
//   registers back to header_length 0, pattern 0, frame_length 1.
// ----------------------------------------------------------------------------
`default_nettype none

module sync_header_frame_extractor_top
    import shfe_pkg::*;
#(
    parameter int MAX_HEADER_BYTES = MAX_HEADER_BYTES_DEF,
    parameter int MAX_FRAME_BYTES  = MAX_FRAME_BYTES_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,

    input  wire logic              i_data_valid,
    output logic                   o_data_ready,
    input  wire logic [7:0]        i_data_byte,

    output logic                   o_frame_valid,
    input  wire logic              i_frame_ready,
    output logic [7:0]             o_frame_byte,
    output logic                   o_first_of_frame,
    output logic                   o_end_of_frame,
    output logic                   o_last_of_run,

    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [CIDX_W-1:0] i_cfg_index,
    input  wire logic [PAT_W-1:0]  i_cfg_data
);

    logic [HLEN_W-1:0] r_header_length;
    logic [PAT_W-1:0]  r_header_pattern;
    logic [FLEN_W-1:0] r_frame_length;

    t_job push_job, head_job;
    logic push, pop, q_full, q_empty;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_length  <= '0;
            r_header_pattern <= '0;
            r_frame_length   <= FLEN_W'(1);
        end else if (i_cfg_valid) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_HEADER_LENGTH:  r_header_length  <= i_cfg_data[HLEN_W-1:0];
                CFG_HEADER_PATTERN: r_header_pattern <= i_cfg_data;
                CFG_FRAME_LENGTH:   r_frame_length   <= i_cfg_data[FLEN_W-1:0];
                default: ;
            endcase
        end
    end

    shfe_front #(
        .MAX_HEADER_BYTES (MAX_HEADER_BYTES),
        .MAX_FRAME_BYTES  (MAX_FRAME_BYTES)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_data_valid),
        .o_ready          (o_data_ready),
        .i_byte           (i_data_byte),
        .i_header_length  (r_header_length),
        .i_header_pattern (r_header_pattern),
        .i_frame_length   (r_frame_length),
        .i_q_full         (q_full),
        .o_push           (push),
        .o_job            (push_job)
    );

    shfe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_head  (head_job),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    shfe_back #(
        .MAX_HEADER_BYTES (MAX_HEADER_BYTES)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_head           (head_job),
        .i_empty          (q_empty),
        .o_pop            (pop),
        .i_header_pattern (r_header_pattern),
        .o_valid          (o_frame_valid),
        .i_ready          (i_frame_ready),
        .o_frame_byte     (o_frame_byte),
        .o_first_of_frame (o_first_of_frame),
        .o_end_of_frame   (o_end_of_frame),
        .o_last_of_run    (o_last_of_run)
    );

endmodule

`default_nettype wire

// ===== tb/sync_header_frame_extractor_top_test.sv =====
// ----------------------------------------------------------------------------
// sync_header_frame_extractor_top_test
// Self-checking bench for the sync header deframer. A scoreboard class tracks
// the hunt window and frame position for every accepted byte and queues the
// frame bytes the block must produce; each output item is checked field by
// field against the oldest one. Directed cases come first, among them two output
// hold-offs, then random setups with header-heavy byte streams and random stalls
// on both sides.
// ----------------------------------------------------------------------------

module sync_header_frame_extractor_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import shfe_pkg::*;

    // index 3 maps to no register, writes must be ignored
    localparam logic [CIDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 260;
    localparam int TAIL_CYCLES  = 8;

    typedef struct {
        logic [7:0] data;
        logic       sof;
        logic       eof;
        logic       last_run;
    } t_frame_byte;

    class deframe_scoreboard;
        logic [HLEN_W-1:0] hdr_len_reg;
        logic [PAT_W-1:0]  pattern_reg;
        logic [FLEN_W-1:0] frame_len_reg;

        logic [63:0]       window;
        logic [3:0]        fill;
        bit                in_frame;
        int unsigned       frame_pos;

        t_frame_byte       frame_bytes_due[$];
        int                mismatches;

        function new();
            hdr_len_reg   = '0;
            pattern_reg   = '0;
            frame_len_reg = 13'd1;
            mismatches    = 0;
            restart_hunt();
        endfunction

        function void restart_hunt();
            in_frame  = 1'b0;
            frame_pos = 0;
            window    = '0;
            fill      = '0;
        endfunction

        function void set_reg(logic [CIDX_W-1:0] idx, logic [PAT_W-1:0] val);
            case (idx)
                CFG_HEADER_LENGTH:  hdr_len_reg   = val[HLEN_W-1:0];
                CFG_HEADER_PATTERN: pattern_reg   = val;
                CFG_FRAME_LENGTH:   frame_len_reg = val[FLEN_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned eff_hdr_len();
            return (hdr_len_reg > MAX_HEADER_BYTES_DEF) ? MAX_HEADER_BYTES_DEF : hdr_len_reg;
        endfunction

        function int pending();
            return frame_bytes_due.size();
        endfunction

        // one accepted input byte: advance state, queue the bytes it releases
        function void take_byte(logic [7:0] b);
            int unsigned hl;
            int unsigned fl;
            bit          hit;
            bit          sof_now;
            hl = eff_hdr_len();
            fl = 32'(frame_len_reg);
            if (fl < hl) fl = hl;
            if (fl < 1) fl = 1;
            if (fl > MAX_FRAME_BYTES_DEF) fl = MAX_FRAME_BYTES_DEF;

            if (in_frame || hl == 0) begin
                sof_now  = !in_frame;
                in_frame = 1'b1;
                frame_pos++;
                frame_bytes_due.push_back('{b, sof_now, frame_pos >= fl, 1'b1});
                if (frame_pos >= fl) restart_hunt();
                return;
            end

            window = {window[55:0], b};
            if (fill < MAX_HEADER_BYTES_DEF) fill++;
            if (fill < hl) return;
            // newest byte lines up with the last header byte
            hit = 1'b1;
            for (int i = 0; i < hl; i++)
                if (window[8*i +: 8] != pattern_reg[8*(hl-1-i) +: 8]) hit = 1'b0;
            if (!hit) return;
            for (int i = 0; i < hl; i++)
                frame_bytes_due.push_back('{pattern_reg[8*i +: 8], i == 0,
                                            (i + 1 == hl) && (hl >= fl), i + 1 == hl});
            if (hl >= fl) begin
                restart_hunt();
            end else begin
                in_frame  = 1'b1;
                frame_pos = hl;
                window    = '0;
                fill      = '0;
            end
        endfunction

        task report(string what, logic [7:0] got, logic [7:0] want);
            $display("%0t: mismatch on %s, got %0h, expected %0h", $realtime, what, got, want);
            mismatches++;
        endtask

        task check_result(logic [7:0] data, logic sof, logic eof, logic last_run);
            t_frame_byte want;
            if (frame_bytes_due.size() == 0) begin
                report("unexpected item", data, 8'h00);
                return;
            end
            want = frame_bytes_due.pop_front();
            if (data !== want.data)
                report("frame_byte", data, want.data);
            if (sof !== want.sof)
                report("first_of_frame", 8'(sof), 8'(want.sof));
            if (eof !== want.eof)
                report("end_of_frame", 8'(eof), 8'(want.eof));
            if (last_run !== want.last_run)
                report("last_of_run", 8'(last_run), 8'(want.last_run));
        endtask
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_data_valid;
    logic              o_data_ready;
    logic [7:0]        i_data_byte;
    logic              o_frame_valid;
    logic              i_frame_ready;
    logic [7:0]        o_frame_byte;
    logic              o_first_of_frame;
    logic              o_end_of_frame;
    logic              o_last_of_run;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [CIDX_W-1:0] i_cfg_index;
    logic [PAT_W-1:0]  i_cfg_data;

    deframe_scoreboard deframe_sb;
    bit tx_gaps;
    bit rx_gaps;
    int hold_left;

    sync_header_frame_extractor_top DUT (.*);

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // output side: random stalls, plus a counted hold-off on request
    initial begin
        i_frame_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_frame_ready <= 1'b0;
            end else begin
                i_frame_ready <= !(rx_gaps && $urandom_range(99) < 12);
            end
        end
    end

    always @(posedge i_clk)
        if (i_rst_n && o_frame_valid && i_frame_ready)
            deframe_sb.check_result(o_frame_byte, o_first_of_frame, o_end_of_frame,
                                    o_last_of_run);

    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // entered at a falling edge, returns at a falling edge with valid still high
    task automatic send_byte(input logic [7:0] b);
        if (tx_gaps)
            while ($urandom_range(99) < 12) begin
                i_data_valid <= 1'b0;
                @(negedge i_clk);
            end
        i_data_valid <= 1'b1;
        i_data_byte  <= b;
        @(posedge i_clk);
        while (!o_data_ready) @(posedge i_clk);
        deframe_sb.take_byte(b);
        @(negedge i_clk);
    endtask

    task automatic put_reg(input logic [CIDX_W-1:0] idx, input logic [PAT_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        deframe_sb.set_reg(idx, val);
        @(negedge i_clk);
    endtask

    task automatic load_setup(input logic [HLEN_W-1:0] hl, input logic [PAT_W-1:0] pat,
                              input logic [FLEN_W-1:0] fl);
        put_reg(CFG_HEADER_LENGTH, PAT_W'(hl));
        put_reg(CFG_HEADER_PATTERN, pat);
        put_reg(CFG_FRAME_LENGTH, PAT_W'(fl));
        i_cfg_valid <= 1'b0;
    endtask

    // drop valid, wait for every due item, then let the pipeline go quiet
    task automatic settle();
        i_data_valid <= 1'b0;
        while (deframe_sb.pending() != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);
    endtask

    task automatic send_header(input logic [PAT_W-1:0] pat, input int unsigned hl);
        for (int k = 0; k < hl; k++) send_byte(pat[8*k +: 8]);
    endtask

    // mostly clean headers followed by frame bodies, some corrupt headers and noise
    task automatic run_burst(input int budget, inout int counted);
        int          done_here;
        int unsigned hl;
        int unsigned bad_k;
        logic [7:0]  hb;
        done_here = 0;
        while (done_here < budget) begin
            hl = deframe_sb.eff_hdr_len();
            if (deframe_sb.in_frame || hl == 0) begin
                send_byte(8'($urandom_range(255)));
                done_here++;
            end else if ($urandom_range(99) < 70) begin
                send_header(deframe_sb.pattern_reg, hl);
                done_here += hl;
            end else if ($urandom_range(1) == 0) begin
                bad_k = $urandom_range(hl - 1);
                for (int k = 0; k < hl; k++) begin
                    hb = deframe_sb.pattern_reg[8*k +: 8];
                    if (k == bad_k) hb = hb ^ (8'h01 << $urandom_range(7));
                    send_byte(hb);
                end
                done_here += hl;
            end else begin
                send_byte(8'($urandom_range(255)));
                done_here++;
            end
        end
        counted += done_here;
    endtask

    initial begin
        logic [HLEN_W-1:0] hl;
        logic [PAT_W-1:0]  pat;
        logic [FLEN_W-1:0] fl;
        logic [7:0]        rb;
        int                random_items;
        int                phase_no;

        deframe_sb   = new();
        tx_gaps      = 1'b1;
        rx_gaps      = 1'b1;
        hold_left    = 0;
        i_rst_n      = 1'b0;
        i_data_valid = 1'b0;
        i_data_byte  = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = CFG_HEADER_LENGTH;
        i_cfg_data   = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset defaults: no hunting, one-byte frames
        send_byte(8'h00);
        send_byte(8'hFF);
        settle();

        // three-byte header behind a partial window, then a short body
        load_setup(4'd3, 64'hFFFF_FFFF_FFC3_A55A, 13'd5);
        send_byte(8'h5A);
        send_byte(8'h00);
        send_header(deframe_sb.pattern_reg, 3);
        send_byte(8'h81);
        send_byte(8'h7E);
        settle();

        // oversize header length, frame length zero: header-only frame,
        // with the output held back so the header burst backs up
        load_setup(4'd15, {64{1'b1}}, 13'd0);
        hold_left = 20;
        send_header(deframe_sb.pattern_reg, MAX_HEADER_BYTES_DEF);
        settle();

        // oversize frame length, then shorten it below the running count
        load_setup(4'd1, 64'h0000_0000_0000_0080, 13'h1FFF);
        send_byte(8'h80);
        send_byte(8'h12);
        send_byte(8'h34);
        settle();
        load_setup(4'd1, 64'h0000_0000_0000_0080, 13'd2);
        send_byte(8'hC5);
        settle();

        // back-pressure: hold the output while frames stream in back to back
        load_setup(4'd0, 64'h0, 13'd7);
        tx_gaps   = 1'b0;
        hold_left = 60;
        for (int k = 0; k < 40; k++) send_byte(8'($urandom_range(255)));
        settle();

        random_items = 0;
        phase_no     = 0;
        while (random_items < RANDOM_ITEMS) begin
            case ($urandom_range(9))
                0:       hl = 4'd0;
                1:       hl = HLEN_W'($urandom_range(15, 9));
                default: hl = HLEN_W'($urandom_range(8, 1));
            endcase
            rb = 8'($urandom_range(255));
            case ($urandom_range(4))
                0:       pat = '0;
                1:       pat = '1;
                2:       pat = {8{rb}};
                default: pat = {$urandom, $urandom};
            endcase
            case ($urandom_range(9))
                0:       fl = FLEN_W'($urandom_range(hl));
                1:       fl = 13'd1;
                2:       fl = ($urandom_range(1) != 0) ? 13'h1FFF : 13'd4096;
                3:       fl = FLEN_W'($urandom_range(8191));
                default: fl = FLEN_W'(hl) + FLEN_W'($urandom_range(16));
            endcase
            if (phase_no % 5 == 1) put_reg(CFG_UNUSED, {$urandom, $urandom});
            load_setup(hl, pat, fl);
            if (phase_no == 0) begin
                tx_gaps = 1'b0;
                rx_gaps = 1'b0;
                run_burst(80, random_items);
            end else begin
                tx_gaps = 1'b1;
                rx_gaps = 1'b1;
                run_burst($urandom_range(40, 15), random_items);
            end
            settle();
            phase_no++;
        end

        repeat (20) @(negedge i_clk);
        if (deframe_sb.mismatches == 0 && deframe_sb.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
